>>> hw/rtl/uart_programmed_pulse_channels_macros.svh
// Assertion macros for the pulse channel RTL; used by the top level.
// Expects clk and rst in the scope of the module that uses them.
`ifndef UART_PROGRAMMED_PULSE_CHANNELS_MACROS_SVH
`define UART_PROGRAMMED_PULSE_CHANNELS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UPPC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define UPPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/uppc_pkg.sv
// Package for the programmed pulse channels: sizes, characters and
// control structs shared by the top level and the channel module.
package uppc_pkg;

  localparam int CHANNEL_COUNT = 3;
  localparam int PIN_COUNT     = 3;
  localparam int FRAME_LEN     = 10;
  localparam int LEN_W         = 4;
  localparam int POS_W         = 4;

  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] DIGIT_BASE = 8'd48;
  localparam logic [7:0] DIGIT_MAX  = 8'd57;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic tick;    // accepted timer tick
    logic load;    // valid frame addresses this channel
    logic reload;  // valid frame: reload counters, pin off
  } chan_ctrl_t;

  typedef struct packed {
    logic [LEN_W-1:0] delay_len;
    logic [LEN_W-1:0] high_len;
    logic [LEN_W-1:0] low_len;
  } chan_len_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= DIGIT_BASE) && (b <= DIGIT_MAX);
  endfunction

  function automatic logic [LEN_W-1:0] digit_val(input logic [7:0] b);
    logic [7:0] diff;
    diff = b - DIGIT_BASE;
    return diff[LEN_W-1:0];
  endfunction

endpackage

>>> hw/rtl/uppc_channel.sv
// One pulse channel: stored lengths, phase counters and pin level.
// Depends on uppc_pkg for the control and length structs.
module uppc_channel (
  input  logic                clk,
  input  logic                rst,
  input  uppc_pkg::chan_ctrl_t ctrl,
  input  uppc_pkg::chan_len_t  lens,
  output logic                pin_next
);

  uppc_pkg::chan_len_t lengths;
  uppc_pkg::chan_len_t lengths_next;
  uppc_pkg::chan_len_t left;
  uppc_pkg::chan_len_t left_next;
  logic                pin_state;

  always_comb begin
    lengths_next = lengths;
    left_next    = left;
    pin_next     = pin_state;
    if (ctrl.reload) begin
      if (ctrl.load) begin
        lengths_next = lens;
      end
      left_next = lengths_next;
      pin_next  = 1'b1;
    end else if (ctrl.tick) begin
      if (left.delay_len != '0) begin
        left_next.delay_len = left.delay_len - 1'b1;
        pin_next            = 1'b1;
      end else if (left.high_len != '0) begin
        left_next.high_len = left.high_len - 1'b1;
        pin_next           = 1'b0;
      end else if (left.low_len != '0) begin
        left_next.low_len = left.low_len - 1'b1;
        pin_next          = 1'b1;
      end else begin
        // all phases spent: reload, hold the pin
        left_next = lengths;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lengths   <= '0;
      left      <= '0;
      pin_state <= 1'b1;
    end else begin
      lengths   <= lengths_next;
      left      <= left_next;
      pin_state <= pin_next;
    end
  end

endmodule

>>> hw/rtl/uart_programmed_pulse_channels.sv
// Programmed pulse channels: frame collection, command check, output register.
// The result of an item is held in the output register from the cycle after it is accepted.
// Throughput: one item per cycle; input stalls only while a held result is stalled.
// Reset clears frame position, channel lengths and counters, and sets all channel pin states off.
// Frame store has no reset; every slot is written before a frame is checked.
// Depends on uppc_pkg, uppc_channel and the assertion macro header.
`include "uart_programmed_pulse_channels_macros.svh"

module uart_programmed_pulse_channels (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] pin_levels,
  output logic       echo_valid,
  output logic [7:0] echo_byte,
  output logic       command_done,
  output logic       command_error
);

  localparam int FL = uppc_pkg::FRAME_LEN;
  localparam int PW = uppc_pkg::POS_W;

  logic [7:0]    frame_store [FL];
  logic [PW-1:0] frame_position;
  logic [PW-1:0] frame_position_next;
  logic [PW-1:0] slot;

  logic in_accept;
  logic byte_item;
  logic tick_item;
  logic frame_full;
  logic frame_ok;
  logic [7:0] chan_diff;
  logic chan_ok;
  logic done_next;
  logic err_next;

  uppc_pkg::chan_len_t lens;
  uppc_pkg::chan_ctrl_t ctrl [uppc_pkg::PIN_COUNT];
  logic [uppc_pkg::PIN_COUNT-1:0] pins_next;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign byte_item = in_accept && (kind == uppc_pkg::KIND_BYTE) && (rx_byte != 8'd0);
  assign tick_item = in_accept && (kind == uppc_pkg::KIND_TICK);

  // 'A' or an out-of-range position restarts the frame
  always_comb begin
    if (rx_byte == uppc_pkg::CHAR_A || frame_position >= PW'(FL)) begin
      slot = '0;
    end else begin
      slot = frame_position;
    end
  end

  assign frame_full = (slot == PW'(FL - 1));

  // Tenth byte arrives now; slots 0..8 are in the store
  assign chan_diff = frame_store[3] - uppc_pkg::DIGIT_BASE;
  assign chan_ok   = (frame_store[3] >= uppc_pkg::DIGIT_BASE) &&
                     (chan_diff < 8'(uppc_pkg::CHANNEL_COUNT));
  assign frame_ok  = (frame_store[0] == uppc_pkg::CHAR_A) &&
                     (frame_store[1] == uppc_pkg::CHAR_T) &&
                     (frame_store[2] == uppc_pkg::CHAR_PLUS) &&
                     (frame_store[4] == uppc_pkg::CHAR_PLUS) &&
                     (frame_store[6] == uppc_pkg::CHAR_PLUS) &&
                     (frame_store[8] == uppc_pkg::CHAR_PLUS) &&
                     uppc_pkg::is_digit(frame_store[5]) &&
                     uppc_pkg::is_digit(frame_store[7]) &&
                     uppc_pkg::is_digit(rx_byte) && chan_ok;

  assign done_next = byte_item && frame_full && frame_ok;
  assign err_next  = byte_item && frame_full && !frame_ok;

  assign lens.delay_len = uppc_pkg::digit_val(frame_store[5]);
  assign lens.high_len  = uppc_pkg::digit_val(frame_store[7]);
  assign lens.low_len   = uppc_pkg::digit_val(rx_byte);

  always_comb begin
    frame_position_next = frame_position;
    if (byte_item) begin
      frame_position_next = frame_full ? '0 : slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_item) begin
      frame_store[slot] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= '0;
    end else begin
      frame_position <= frame_position_next;
    end
  end

  for (genvar i = 0; i < uppc_pkg::PIN_COUNT; i++) begin : g_chan
    if (i < uppc_pkg::CHANNEL_COUNT) begin : g_live
      assign ctrl[i].tick   = tick_item;
      assign ctrl[i].reload = done_next;
      assign ctrl[i].load   = done_next && (chan_diff == 8'(i));

      uppc_channel u_channel (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl[i]),
        .lens     (lens),
        .pin_next (pins_next[i])
      );
    end else begin : g_off
      assign ctrl[i]      = '0;
      assign pins_next[i] = 1'b1 | ctrl[i].tick;
    end
  end

  // Output register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pin_levels    <= pins_next;
      echo_valid    <= byte_item;
      echo_byte     <= byte_item ? rx_byte : 8'd0;
      command_done  <= done_next;
      command_error <= err_next;
    end
  end

  `UPPC_ASSERT_IMPLY(a_done_xor_err, out_valid, !(command_done && command_error), "done and error together")
  `UPPC_ASSERT_IMPLY(a_cmd_needs_echo, out_valid && (command_done || command_error), echo_valid, "command result without echo")
  `UPPC_ASSERT_IMPLY(a_done_pins_off, out_valid && command_done, pin_levels == 3'b111, "pins not off after command")
  `UPPC_ASSERT_NEXT(a_tick_no_echo, tick_item, out_valid && !echo_valid && !command_done && !command_error, "tick gave byte result")
  `UPPC_ASSERT_IMPLY(a_pos_range, 1'b1, frame_position <= PW'(FL - 1), "frame position out of range")

endmodule
